// ===== rtl/kth_pkg.sv =====
// Package for the rank-removal tree: field widths, mode codes and the
// record that passes between neighbouring tree-level cells. No dependencies.
package kth_pkg;

  localparam int VALUE_W = 32;
  localparam int RANK_W = 11;

  // Largest tree depth and count width allowed by the capacity range.
  localparam int NODE_W = 16;
  localparam int CNT_MAX_W = 17;

  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // Token handed from one level cell to the next.
  typedef struct packed {
    logic                 valid;
    logic                 remove;
    logic [NODE_W-1:0]    node;
    logic [CNT_MAX_W-1:0] k;
    logic [CNT_MAX_W-1:0] cnt;
  } kth_link_t;

endpackage

// ===== rtl/kth_channels.sv =====
// Valid/ready channel interfaces for the request and result beats.
// Depends on kth_pkg for the field widths.
interface kth_in_if;
  import kth_pkg::*;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [VALUE_W-1:0] item_value;
  logic [RANK_W-1:0]  rank;

  modport source (output valid, output mode, output item_value, output rank, input ready);
  modport sink (input valid, input mode, input item_value, input rank, output ready);
endinterface

interface kth_out_if;
  import kth_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] removed_value;
  logic               rank_error;

  modport source (output valid, output removed_value, output rank_error, input ready);
  modport sink (input valid, input removed_value, input rank_error, output ready);
endinterface

// ===== rtl/kth_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependencies.
module kth_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old data; the read data is held while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/kth_cell.sv =====
// One level of the present-count tree: its count RAM, the step decision
// and the token register. Depends on kth_pkg and kth_ram.
module kth_cell #(
  parameter int LEVEL  = 1,
  parameter int LEVELS = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [LEVELS:0]   fill,
  input  kth_pkg::kth_link_t up,
  output kth_pkg::kth_link_t down
);
  import kth_pkg::*;

  localparam int SHIFT = LEVELS - LEVEL;
  localparam int CW    = SHIFT + 1;
  localparam int CNT_W = LEVELS + 1;
  localparam int DEPTH = 2 ** LEVEL;

  logic [NODE_W:0]     up_left;
  logic [CNT_W-1:0]    fill_node;
  logic [LEVEL-1:0]    rd_addr;
  logic                vld;
  logic                rm;
  logic [LEVEL-1:0]    addr;
  logic [CNT_W-1:0]    k;
  logic [CNT_W-1:0]    cnt;
  logic [CW-1:0]       q;
  logic [CNT_W-1:0]    start;
  logic                live;
  logic [CNT_W-1:0]    cnt_rd;
  logic                go_left;
  logic [LEVEL-1:0]    child;
  logic [CNT_W-1:0]    child_cnt;
  logic [CNT_W-1:0]    k_next;
  logic [CNT_W-1:0]    wsum;

  // A removal reads the left child of the node chosen above; an append
  // reads the node that holds the slot being filled.
  assign up_left   = {up.node, 1'b0};
  assign fill_node = fill >> SHIFT;
  assign rd_addr   = up.remove ? up_left[LEVEL-1:0] : fill_node[LEVEL-1:0];

  // Token register; the RAM read lands in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= up.valid;
    end
    if (up.valid) begin
      rm   <= up.remove;
      addr <= rd_addr;
      k    <= up.k[CNT_W-1:0];
      cnt  <= up.cnt[CNT_W-1:0];
    end
  end

  kth_ram #(
    .WIDTH(CW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (vld),
    .waddr (child),
    .wdata (wsum[CW-1:0]),
    .re    (up.valid),
    .raddr (rd_addr),
    .rdata (q)
  );

  // A node whose first slot lies at or past the fill point was never
  // written and counts as empty.
  assign start  = CNT_W'(addr) << SHIFT;
  assign live   = start < fill;
  assign cnt_rd = live ? CNT_W'(q) : '0;

  // Step decision: a removal goes left when the left count covers the rank, else
  // right with the rank reduced by the left count; an append keeps its node.
  always_comb begin
    go_left   = cnt_rd >= k;
    child     = addr;
    child_cnt = cnt_rd;
    k_next    = k;
    if (rm && !go_left) begin
      child[0]  = 1'b1;
      child_cnt = cnt - cnt_rd;
      k_next    = k - cnt_rd;
    end
    wsum = rm ? child_cnt - CNT_W'(1) : cnt_rd + CNT_W'(1);
  end

  assign down.valid  = vld;
  assign down.remove = rm;
  assign down.node   = NODE_W'(child);
  assign down.k      = CNT_MAX_W'(k_next);
  assign down.cnt    = CNT_MAX_W'(child_cnt);

endmodule

// ===== rtl/kth_element_removal_tree.sv =====
// Ordered list with removal by rank, built as a chain of tree-level cells.
// Channel req carries one beat per operation: mode 0 appends item_value at
// the next free slot, mode 1 removes the element of one-based rank.
// Channel rsp carries one beat per removal (none per append): the removed
// value, or zero with rank_error set when the rank is zero or above the
// number of present elements. A bad rank changes nothing; an append past
// CAPACITY is dropped without a result.
// One operation is in flight at a time: a beat is taken in ST_IDLE, checked
// in ST_CHECK and walked down the cells in ST_WALK, one tree level per cycle,
// each level with its own count RAM; a removal then reads its value in
// ST_READ and loads the output register once that register is free. The
// next beat is taken when the sequencer is back in ST_IDLE.
// Reset (rst, synchronous) empties the list at once: no clearing pass is
// run, as count entries beyond the fill point read as zero.
// The result sits in an output register, so a new request is accepted
// while rsp is stalled; a following result waits in ST_CHECK or ST_READ until rsp drains.
module kth_element_removal_tree #(
  parameter int CAPACITY = 1024
) (
  input logic         clk,
  input logic         rst,
  kth_in_if.sink      req,
  kth_out_if.source   rsp
);
  import kth_pkg::*;

  localparam int LEVELS = $clog2(CAPACITY);
  localparam int CNT_W  = LEVELS + 1;
  localparam int CMP_W  = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_READ  = 2'd3;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic               item_mode;
  logic [VALUE_W-1:0] item_value;
  logic [RANK_W-1:0]  item_rank;
  logic [CNT_W-1:0]   fill;
  logic [CNT_W-1:0]   total;
  logic               res_valid;
  logic [VALUE_W-1:0] res_value;
  logic               res_error;
  kth_link_t          link [LEVELS+1];
  kth_link_t          leaf;
  logic [LEVELS:0]    link_vld;
  logic               out_free;
  logic               full;
  logic               rank_bad;
  logic               launch;
  logic               err_load;
  logic               val_load;
  logic               val_we;
  logic               val_re;
  logic [VALUE_W-1:0] val_q;

  assign req.ready = (state == ST_IDLE);
  assign out_free  = !res_valid || rsp.ready;
  assign full      = (fill == CNT_W'(CAPACITY));
  assign rank_bad  = (item_rank == '0) || (CMP_W'(item_rank) > CMP_W'(total));
  assign leaf      = link[LEVELS];

  // Operation sequencer.
  always_comb begin
    state_next = state;
    launch     = 1'b0;
    err_load   = 1'b0;
    val_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (item_mode == MODE_APPEND) begin
          if (full) begin
            state_next = ST_IDLE;
          end else begin
            launch     = 1'b1;
            state_next = ST_WALK;
          end
        end else if (rank_bad) begin
          if (out_free) begin
            err_load   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          launch     = 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (leaf.valid) begin
          state_next = leaf.remove ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free) begin
          val_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State, request capture, fill point and present count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      total <= '0;
    end else begin
      state <= state_next;
      if (leaf.valid) begin
        if (leaf.remove) begin
          total <= total - CNT_W'(1);
        end else begin
          fill  <= fill + CNT_W'(1);
          total <= total + CNT_W'(1);
        end
      end
    end
    if (req.valid && req.ready) begin
      item_mode  <= req.mode;
      item_value <= req.item_value;
      item_rank  <= req.rank;
    end
  end

  // Token entering the root side of the chain.
  assign link[0].valid  = launch;
  assign link[0].remove = (item_mode == MODE_REMOVE);
  assign link[0].node   = '0;
  assign link[0].k      = CNT_MAX_W'(item_rank);
  assign link[0].cnt    = CNT_MAX_W'(total);

  // One cell per tree level below the root.
  for (genvar j = 1; j <= LEVELS; j++) begin : g_level
    kth_cell #(
      .LEVEL  (j),
      .LEVELS (LEVELS)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .fill (fill),
      .up   (link[j-1]),
      .down (link[j])
    );
  end

  for (genvar j = 0; j <= LEVELS; j++) begin : g_vld
    assign link_vld[j] = link[j].valid;
  end

  // Element values, written on append and read at the slot the walk found.
  assign val_we = launch && (item_mode == MODE_APPEND);
  assign val_re = leaf.valid && leaf.remove;

  kth_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_values (
    .clk   (clk),
    .we    (val_we),
    .waddr (fill[LEVELS-1:0]),
    .wdata (item_value),
    .re    (val_re),
    .raddr (leaf.node[LEVELS-1:0]),
    .rdata (val_q)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (err_load || val_load) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
    if (err_load) begin
      res_value <= '0;
      res_error <= 1'b1;
    end else if (val_load) begin
      res_value <= val_q;
      res_error <= 1'b0;
    end
  end

  assign rsp.valid         = res_valid;
  assign rsp.removed_value = res_value;
  assign rsp.rank_error    = res_error;

`ifndef NO_ASSERTIONS
  // Removals never take out more elements than were appended.
  a_total_fill : assert property (@(posedge clk) disable iff (rst) total <= fill)
    else $error("present count exceeds fill point");

  // Only one token travels down the chain at a time.
  a_one_token : assert property (@(posedge clk) disable iff (rst) $onehot0(link_vld))
    else $error("more than one token in the level chain");

  // A token leaves the leaf level only during a walk.
  a_leaf_walk : assert property (@(posedge clk) disable iff (rst)
    leaf.valid |-> state == ST_WALK)
    else $error("leaf token outside a walk");
`endif

endmodule

// ===== dv/tb_kth_element_removal_tree.sv =====
// Self-checking testbench for kth_element_removal_tree: appends and rank removals are
// driven on the req channel and removal results are checked against a software copy of
// the count tree. Depends on kth_pkg, kth_in_if, kth_out_if and the tree module.
module tb_kth_element_removal_tree;
  timeunit 1ns;
  timeprecision 1ps;

  import kth_pkg::*;

  localparam int CAPACITY = 1024;
  localparam int TREE_NODES = 4 * CAPACITY;
  localparam int RANK_MAX = (1 << RANK_W) - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 64;

  // Idling regimes, in the order they are run.
  typedef enum int {SEND_LIGHT, SEND_HEAVY, NO_IDLE} idle_phase_t;

  typedef struct {
    logic               mode;
    logic [VALUE_W-1:0] item_value;
    logic [RANK_W-1:0]  rank;
    bit                 drain;
    idle_phase_t        phase;
  } request_t;

  typedef struct packed {
    logic [VALUE_W-1:0] removed_value;
    logic               rank_error;
  } removal_t;

  logic clk;
  logic rst;

  kth_in_if req_ch ();
  kth_out_if rsp_ch ();

  kth_element_removal_tree #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Pending request beats and the removal results still owed by the block.
  request_t    request_q[$];
  removal_t    removal_q[$];
  int unsigned removals_predicted;
  int unsigned removals_checked;
  int unsigned error_count;
  int unsigned cycle_count;
  idle_phase_t idle_phase;

  // Software copy of the block state.
  int unsigned        tree_cnt[TREE_NODES];
  logic [VALUE_W-1:0] slot_value[CAPACITY];
  int unsigned        fill_level;

  // Shadow counts used only to shape the stimulus.
  int unsigned gen_fill;
  int unsigned gen_present;
  int unsigned gen_ignored;

  // One line per mismatch, and each one is counted.
  task automatic flag_mismatch(input string what);
    error_count++;
    $display("mismatch: %s", what);
  endtask

  // Add one to, or take one from, every count on the path down to a slot.
  function automatic void adjust_counts(input int unsigned slot, input bit take_away);
    int unsigned lo;
    int unsigned hi;
    int unsigned node;
    int unsigned mid;
    lo = 0;
    hi = CAPACITY - 1;
    node = 1;
    while (node < TREE_NODES) begin
      if (take_away) begin
        tree_cnt[node] = tree_cnt[node] - 1;
      end else begin
        tree_cnt[node] = tree_cnt[node] + 1;
      end
      if (lo >= hi) begin
        break;
      end
      mid = (lo + hi) / 2;
      if (slot <= mid) begin
        hi = mid;
        node = node * 2;
      end else begin
        lo = mid + 1;
        node = node * 2 + 1;
      end
    end
  endfunction

  // Apply one accepted request beat and queue the result it owes, if any.
  function automatic void rank_tree_step(input logic mode, input logic [VALUE_W-1:0] val,
                                         input logic [RANK_W-1:0] rank);
    int unsigned lo;
    int unsigned hi;
    int unsigned node;
    int unsigned mid;
    int unsigned k;
    removal_t    res;
    if (mode == MODE_APPEND) begin
      if (fill_level < CAPACITY) begin
        slot_value[fill_level] = val;
        adjust_counts(fill_level, 1'b0);
        fill_level++;
      end
    end else begin
      if (rank == 0 || rank > tree_cnt[1]) begin
        res.removed_value = '0;
        res.rank_error = 1'b1;
      end else begin
        lo = 0;
        hi = CAPACITY - 1;
        node = 1;
        k = rank;
        // Walk down: left when the left count covers k, else skip past it.
        while (lo < hi) begin
          mid = (lo + hi) / 2;
          if (tree_cnt[node * 2] >= k) begin
            hi = mid;
            node = node * 2;
          end else begin
            k = k - tree_cnt[node * 2];
            lo = mid + 1;
            node = node * 2 + 1;
          end
        end
        res.removed_value = slot_value[lo];
        res.rank_error = 1'b0;
        adjust_counts(lo, 1'b1);
      end
      removal_q.push_back(res);
      removals_predicted++;
    end
  endfunction

  function automatic int send_idle_pct(input idle_phase_t ph);
    case (ph)
      SEND_LIGHT: send_idle_pct = 33;
      SEND_HEAVY: send_idle_pct = 66;
      default:    send_idle_pct = 0;
    endcase
  endfunction

  function automatic int recv_idle_pct(input idle_phase_t ph);
    case (ph)
      SEND_LIGHT: recv_idle_pct = 66;
      SEND_HEAVY: recv_idle_pct = 33;
      default:    recv_idle_pct = 0;
    endcase
  endfunction

  // Queue one request beat, keeping the shadow counts in step.
  function automatic void queue_request(input logic mode, input logic [VALUE_W-1:0] val,
                                        input int rank, input bit drain,
                                        input idle_phase_t ph);
    request_t r;
    r.mode = mode;
    r.item_value = val;
    r.rank = rank[RANK_W-1:0];
    r.drain = drain;
    r.phase = ph;
    request_q.push_back(r);
    if (mode == MODE_APPEND) begin
      if (gen_fill < CAPACITY) begin
        gen_fill++;
        gen_present++;
      end else begin
        gen_ignored++;
      end
    end else if (rank != 0 && rank <= gen_present) begin
      gen_present--;
    end
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Cycle counter with a hard stop.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Driver: presents queued beats, holds each until accepted, idles at random.
  always @(posedge clk) begin
    bit       nxt_valid;
    request_t head;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      nxt_valid = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        rank_tree_step(req_ch.mode, req_ch.item_value, req_ch.rank);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && request_q.size() > 0) begin
        head = request_q[0];
        // A drain beat waits until every owed result has been seen.
        if (!(head.drain && removals_predicted != removals_checked) &&
            $urandom_range(99) >= send_idle_pct(head.phase)) begin
          void'(request_q.pop_front());
          nxt_valid = 1'b1;
          req_ch.mode <= head.mode;
          req_ch.item_value <= head.item_value;
          req_ch.rank <= head.rank;
          idle_phase <= head.phase;
        end
      end
      req_ch.valid <= nxt_valid;
    end
  end

  // Monitor: checks each result beat against the oldest expectation.
  always @(posedge clk) begin
    removal_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (removal_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result beat value=%h error=%b",
                                  rsp_ch.removed_value, rsp_ch.rank_error));
        end else begin
          want = removal_q.pop_front();
          removals_checked <= removals_checked + 1;
          if (rsp_ch.removed_value !== want.removed_value) begin
            flag_mismatch($sformatf("removed_value %h, expected %h",
                                    rsp_ch.removed_value, want.removed_value));
          end
          if (rsp_ch.rank_error !== want.rank_error) begin
            flag_mismatch($sformatf("rank_error %b, expected %b",
                                    rsp_ch.rank_error, want.rank_error));
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct(idle_phase));
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int          i;
    int          rank;
    idle_phase_t ph;
    bit          drain;
    logic [VALUE_W-1:0] val;

    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_APPEND;
    req_ch.item_value = '0;
    req_ch.rank = '0;
    rsp_ch.ready = 1'b0;
    idle_phase = SEND_LIGHT;
    removals_predicted = 0;
    removals_checked = 0;
    error_count = 0;
    cycle_count = 0;
    fill_level = 0;
    gen_fill = 0;
    gen_present = 0;
    gen_ignored = 0;
    foreach (tree_cnt[n]) tree_cnt[n] = 0;
    foreach (slot_value[n]) slot_value[n] = '0;

    // Directed: bad ranks on an empty list, extreme values, first, last and middle.
    queue_request(MODE_REMOVE, $urandom, 0, 1'b0, SEND_LIGHT);
    queue_request(MODE_REMOVE, $urandom, 1, 1'b0, SEND_LIGHT);
    queue_request(MODE_REMOVE, $urandom, RANK_MAX, 1'b0, SEND_LIGHT);
    queue_request(MODE_APPEND, 32'hFFFF_FFFF, $urandom_range(RANK_MAX), 1'b0, SEND_LIGHT);
    queue_request(MODE_APPEND, 32'h0000_0000, $urandom_range(RANK_MAX), 1'b0, SEND_LIGHT);
    queue_request(MODE_APPEND, 32'hA5A5_A5A5, $urandom_range(RANK_MAX), 1'b0, SEND_LIGHT);
    queue_request(MODE_APPEND, 32'h5A5A_5A5A, $urandom_range(RANK_MAX), 1'b0, SEND_LIGHT);
    queue_request(MODE_APPEND, 32'h0000_0001, $urandom_range(RANK_MAX), 1'b0, SEND_LIGHT);
    queue_request(MODE_REMOVE, $urandom, 0, 1'b0, SEND_LIGHT);
    queue_request(MODE_REMOVE, $urandom, 6, 1'b0, SEND_LIGHT);
    queue_request(MODE_REMOVE, $urandom, CAPACITY, 1'b0, SEND_LIGHT);
    queue_request(MODE_REMOVE, $urandom, 5, 1'b0, SEND_LIGHT);
    queue_request(MODE_REMOVE, $urandom, 1, 1'b0, SEND_LIGHT);
    queue_request(MODE_REMOVE, $urandom, 2, 1'b0, SEND_LIGHT);
    queue_request(MODE_REMOVE, $urandom, 2, 1'b0, SEND_LIGHT);
    queue_request(MODE_REMOVE, $urandom, 1, 1'b0, SEND_LIGHT);
    queue_request(MODE_REMOVE, $urandom, 1, 1'b1, SEND_LIGHT);
    queue_request(MODE_APPEND, 32'h8000_0000, $urandom_range(RANK_MAX), 1'b0, SEND_LIGHT);
    queue_request(MODE_APPEND, 32'h7FFF_FFFF, $urandom_range(RANK_MAX), 1'b0, SEND_LIGHT);
    queue_request(MODE_REMOVE, $urandom, 2, 1'b0, SEND_LIGHT);

    // Random part: mostly appends so that the list fills, removals at random ranks,
    // and a run of appends past capacity once it is full.
    i = 0;
    while (i < 1060 || gen_fill < CAPACITY || gen_ignored < 8) begin
      if (i < 420) begin
        ph = SEND_LIGHT;
      end else if (i < 840) begin
        ph = SEND_HEAVY;
      end else begin
        ph = NO_IDLE;
      end
      drain = (i == 420) || (i == 840) || ($urandom_range(99) == 0);
      if ($urandom_range(99) < 8) begin
        if (gen_present > 0 && $urandom_range(99) < 85) begin
          case ($urandom_range(9))
            0:       rank = 1;
            1:       rank = gen_present;
            default: rank = $urandom_range(gen_present, 1);
          endcase
        end else if ($urandom_range(1) == 0) begin
          rank = 0;
        end else begin
          rank = $urandom_range(RANK_MAX, gen_present + 1);
        end
        queue_request(MODE_REMOVE, $urandom, rank, drain, ph);
      end else begin
        case ($urandom_range(15))
          0:       val = '0;
          1:       val = '1;
          default: val = $urandom;
        endcase
        queue_request(MODE_APPEND, val, $urandom_range(RANK_MAX), drain, ph);
      end
      i++;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Wait for every beat to go in, then for every owed result to come out.
    while (request_q.size() != 0 || req_ch.valid) @(posedge clk);
    while (removals_checked != removals_predicted) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (removal_q.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", removal_q.size()));
    end

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
